@@ src/ours_pkg.sv @@
`timescale 1ns / 1ps

package ours_pkg;

  localparam int PARTICLES_DEF = 64;

  localparam int WEIGHT_W   = 16;
  localparam int SPACING_W  = 16;
  localparam int PREFIX_W   = 22;
  localparam int WTOT_W     = 22;
  localparam int STOT_W     = 23;
  localparam int CDF_W      = 22;
  localparam int INDEX_W    = 6;
  localparam int THR_W      = PREFIX_W + WTOT_W;
  localparam int PROD_W     = CDF_W + STOT_W;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [2:0] {
    STEP_IDLE,
    STEP_INIT,
    STEP_FETCH,
    STEP_MULT,
    STEP_TEST,
    STEP_ADV
  } step_e;

  typedef enum logic [1:0] {
    BR_GOTO,
    BR_INPUT,
    BR_TEST
  } branch_e;

  typedef enum logic [1:0] {
    CDF_HOLD,
    CDF_LOAD,
    CDF_ADD
  } cdf_op_e;

  typedef struct packed {
    logic    load_en;
    logic    idx_clr;
    cdf_op_e cdf_op;
    logic    mul_en;
    logic    test_en;
    branch_e branch;
    step_e   target;
  } ctrl_t;

  typedef struct packed {
    logic in_last;
    logic adv;
    logic emit;
    logic emit_final;
  } flags_t;

  function automatic ctrl_t ucode_rom(step_e step);
    ctrl_t w;
    w = '{load_en: 1'b0, idx_clr: 1'b0, cdf_op: CDF_HOLD, mul_en: 1'b0,
          test_en: 1'b0, branch: BR_GOTO, target: STEP_IDLE};
    case (step)
      STEP_IDLE: begin
        w.load_en = 1'b1;
        w.branch  = BR_INPUT;
        w.target  = STEP_INIT;
      end
      STEP_INIT: begin
        w.idx_clr = 1'b1;
        w.target  = STEP_FETCH;
      end
      STEP_FETCH: begin
        w.cdf_op = CDF_LOAD;
        w.target = STEP_MULT;
      end
      STEP_MULT: begin
        w.mul_en = 1'b1;
        w.target = STEP_TEST;
      end
      STEP_TEST: begin
        w.test_en = 1'b1;
        w.branch  = BR_TEST;
        w.target  = STEP_MULT;
      end
      STEP_ADV: begin
        w.cdf_op = CDF_ADD;
        w.target = STEP_MULT;
      end
      default: begin
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

@@ src/ours_seq.sv @@
`timescale 1ns / 1ps

module ours_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ours_pkg::flags_t flags_i,
  output ours_pkg::ctrl_t  ctrl_o
);

  ours_pkg::step_e upc_q, upc_d;
  ours_pkg::ctrl_t word;

  assign word   = ours_pkg::ucode_rom(upc_q);
  assign ctrl_o = word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= ours_pkg::STEP_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  always_comb begin
    upc_d = upc_q;
    case (word.branch)
      ours_pkg::BR_GOTO: begin
        upc_d = word.target;
      end
      ours_pkg::BR_INPUT: begin
        if (flags_i.in_last) begin
          upc_d = word.target;
        end
      end
      ours_pkg::BR_TEST: begin
        if (flags_i.adv) begin
          upc_d = ours_pkg::STEP_ADV;
        end else if (flags_i.emit_final) begin
          upc_d = ours_pkg::STEP_IDLE;
        end else if (flags_i.emit) begin
          upc_d = word.target;
        end
      end
      default: begin
        upc_d = ours_pkg::STEP_IDLE;
      end
    endcase
  end

endmodule

@@ src/ours_dp.sv @@
`timescale 1ns / 1ps

module ours_dp #(
  parameter int PARTICLES = ours_pkg::PARTICLES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ours_pkg::ctrl_t                   ctrl_i,
  output ours_pkg::flags_t                  flags_o,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [ours_pkg::WEIGHT_W-1:0]     weight_i,
  input  logic [ours_pkg::SPACING_W-1:0]    spacing_i,
  input  logic [ours_pkg::SPACING_W-1:0]    final_spacing_i,
  input  logic                              last_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ours_pkg::INDEX_W-1:0]      ancestor_index_o,
  output logic                              last_index_o
);

  localparam int AW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
  localparam int CW = $clog2(PARTICLES + 1);

  logic [ours_pkg::WEIGHT_W-1:0] wmem [PARTICLES];
  logic [ours_pkg::PREFIX_W-1:0] pmem [PARTICLES];

  logic [CW-1:0]                 count_q, count_d;
  logic [ours_pkg::WTOT_W-1:0]   wtot_q, wtot_d;
  logic [ours_pkg::STOT_W-1:0]   stot_q, stot_d;
  logic [AW-1:0]                 i_q, i_d, j_q, j_d;
  logic [ours_pkg::CDF_W-1:0]    cdf_q, cdf_d;
  logic [ours_pkg::WEIGHT_W-1:0] w_rd_q;
  logic [ours_pkg::PREFIX_W-1:0] p_rd_q;
  logic [ours_pkg::THR_W-1:0]    thr_q, thr_full;
  logic [ours_pkg::PROD_W-1:0]   prod_q, prod_full;
  logic                          out_valid_q;
  logic [ours_pkg::INDEX_W-1:0]  out_idx_q;
  logic                          out_last_q;

  logic                          accept, store, full;
  logic [ours_pkg::STOT_W-1:0]   sp_sum, stot_load;
  logic [CW-1:0]                 i_inc, j_inc;
  logic                          more, lt, out_free, adv, emit, emit_final;

  assign in_ready_o = ctrl_i.load_en;
  assign accept     = in_valid_i && ctrl_i.load_en;
  assign full       = (count_q == CW'(PARTICLES));
  assign store      = accept && !full;
  assign sp_sum     = stot_q + ours_pkg::STOT_W'(spacing_i);
  assign stot_load  = store ? sp_sum : stot_q;

  assign i_inc      = CW'(i_q) + CW'(1);
  assign j_inc      = CW'(j_q) + CW'(1);
  assign more       = (j_inc < count_q);
  assign lt         = (prod_q < ours_pkg::PROD_W'(thr_q));
  assign out_free   = !out_valid_q || out_ready_i;
  assign adv        = ctrl_i.test_en && more && lt;
  assign emit       = ctrl_i.test_en && !(more && lt) && out_free;
  assign emit_final = emit && (i_inc == count_q);

  assign flags_o.in_last    = accept && last_i;
  assign flags_o.adv        = adv;
  assign flags_o.emit       = emit;
  assign flags_o.emit_final = emit_final;

  assign thr_full  = p_rd_q * wtot_q;
  assign prod_full = cdf_q * stot_q;

  always_comb begin
    count_d = count_q;
    wtot_d  = wtot_q;
    stot_d  = stot_q;
    if (emit_final) begin
      count_d = '0;
      wtot_d  = '0;
      stot_d  = '0;
    end else if (accept) begin
      if (store) begin
        count_d = count_q + CW'(1);
        wtot_d  = wtot_q + ours_pkg::WTOT_W'(weight_i);
      end
      stot_d = last_i ? stot_load + ours_pkg::STOT_W'(final_spacing_i) : stot_load;
    end
  end

  always_comb begin
    i_d = i_q;
    j_d = j_q;
    if (ctrl_i.idx_clr) begin
      i_d = '0;
      j_d = '0;
    end else if (adv) begin
      j_d = j_q + AW'(1);
    end else if (emit && !emit_final) begin
      i_d = i_q + AW'(1);
    end
  end

  always_comb begin
    case (ctrl_i.cdf_op)
      ours_pkg::CDF_LOAD: cdf_d = ours_pkg::CDF_W'(w_rd_q);
      ours_pkg::CDF_ADD:  cdf_d = cdf_q + ours_pkg::CDF_W'(w_rd_q);
      default:            cdf_d = cdf_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      wmem[count_q[AW-1:0]] <= weight_i;
      pmem[count_q[AW-1:0]] <= sp_sum[ours_pkg::PREFIX_W-1:0];
    end
    w_rd_q <= wmem[j_d];
    p_rd_q <= pmem[i_d];
  end

  always_ff @(posedge clk_i) begin
    cdf_q <= cdf_d;
    if (ctrl_i.mul_en) begin
      thr_q  <= thr_full;
      prod_q <= prod_full;
    end
    if (emit) begin
      out_idx_q  <= ours_pkg::INDEX_W'(j_q);
      out_last_q <= emit_final;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      wtot_q      <= '0;
      stot_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      wtot_q  <= wtot_d;
      stot_q  <= stot_d;
      i_q     <= i_d;
      j_q     <= j_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign ancestor_index_o = out_idx_q;
  assign last_index_o     = out_last_q;

endmodule

@@ src/ordered_uniform_resampler.sv @@
// While idle, loading accepts one transaction per cycle; a transaction without tlast produces
// no output. After the tlast transaction the walk clears the indices, loads the CDF with the
// first weight, then forms threshold and product and tests them; each CDF advance (at most
// n - 1 with n particles loaded) adds the next weight, and a finished index waits on tready.
// Reset clears the sequencer, count, both totals, indices and output valid flag; the weight
// and prefix memories are not cleared and are only used after being written in a run.
`timescale 1ns / 1ps

module ordered_uniform_resampler #(
  parameter int PARTICLES = ours_pkg::PARTICLES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata: weight [15:0], spacing [31:16], final_spacing [47:32].
  input  logic [ours_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  input  logic                               s_axis_tlast_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // tdata: ancestor_index [5:0], zero fill [7:6].
  output logic [ours_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  output logic                               m_axis_tlast_o
);

  ours_pkg::ctrl_t              ctrl;
  ours_pkg::flags_t             flags;
  logic [ours_pkg::INDEX_W-1:0] anc_idx;

  ours_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  ours_dp #(
    .PARTICLES (PARTICLES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .flags_o          (flags),
    .in_valid_i       (s_axis_tvalid_i),
    .in_ready_o       (s_axis_tready_o),
    .weight_i         (s_axis_tdata_i[15:0]),
    .spacing_i        (s_axis_tdata_i[31:16]),
    .final_spacing_i  (s_axis_tdata_i[47:32]),
    .last_i           (s_axis_tlast_i),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .ancestor_index_o (anc_idx),
    .last_index_o     (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = ours_pkg::OUT_DATA_W'(anc_idx);

endmodule
